// ===== hdl/cat_pkg.sv =====
// ----------------------------------------------------------------------------
// cat_pkg
// Shared types and constants of the comment-aware tokenizer: byte codes,
// configuration register indexes and the classified item passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package cat_pkg;

    localparam int MAX_TOKEN_LEN  = 256;
    localparam int MAX_SEPARATORS = 8;
    localparam int Q_DEPTH        = 2;

    localparam int LEN_W     = $clog2(MAX_TOKEN_LEN + 1);
    localparam int SEP_CNT_W = 4;
    localparam int SEP_W     = 8 * MAX_SEPARATORS;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    localparam logic [7:0] NUL_CODE     = 8'h00;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] HASH_CODE    = 8'h23;
    localparam logic [7:0] UPPER_A      = 8'h41;
    localparam logic [7:0] UPPER_Z      = 8'h5A;
    localparam logic [7:0] CASE_BIT     = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_SEP_CHARS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_CASE = 2'd2;

    // one text byte after classification
    typedef struct packed {
        logic [7:0] text;     // already lower-cased when enabled
        logic       is_nul;
        logic       is_nl;
        logic       is_sep;
        logic       is_hash;
        logic       eod;
    } t_item;

endpackage

// ===== hdl/cat_front.sv =====
// ----------------------------------------------------------------------------
// cat_front
// Input side: holds the configuration registers, accepts text bytes and
// classifies each one (NUL, newline, separator, hash, case folding).
// ----------------------------------------------------------------------------
module cat_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cat_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cat_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    input  logic [7:0]                     i_text_byte,
    input  logic                           i_end_of_data,
    input  logic                           i_q_full,
    output logic                           o_in_stall,
    output logic                           o_push,
    output cat_pkg::t_item                 o_item
);
    import cat_pkg::*;

    logic [SEP_W-1:0]     r_sep_chars;
    logic [SEP_CNT_W-1:0] r_sep_count;
    logic                 r_lower_case;
    logic                 sep_hit;
    logic                 is_upper;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_chars  <= '0;
            r_sep_count  <= '0;
            r_lower_case <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEP_CHARS:  r_sep_chars  <= i_cfg_data[SEP_W-1:0];
                CFG_SEP_COUNT:  r_sep_count  <= i_cfg_data[SEP_CNT_W-1:0];
                CFG_LOWER_CASE: r_lower_case <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // counts above the slot count simply enable every slot
    always_comb begin
        sep_hit = 1'b0;
        for (int i = 0; i < MAX_SEPARATORS; i++) begin
            if (r_sep_count > SEP_CNT_W'(i) && r_sep_chars[8*i +: 8] == i_text_byte)
                sep_hit = 1'b1;
        end
    end

    assign is_upper = (i_text_byte >= UPPER_A) && (i_text_byte <= UPPER_Z);

    always_comb begin
        o_item.text    = (r_lower_case && is_upper) ? (i_text_byte | CASE_BIT) : i_text_byte;
        o_item.is_nul  = (i_text_byte == NUL_CODE);
        o_item.is_nl   = (i_text_byte == NEWLINE_CODE);
        o_item.is_sep  = sep_hit && (i_text_byte != NUL_CODE);
        o_item.is_hash = (i_text_byte == HASH_CODE);
        o_item.eod     = i_end_of_data;
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule

// ===== hdl/cat_queue.sv =====
// ----------------------------------------------------------------------------
// cat_queue
// Short queue of classified bytes between the front end and the back end.
// ----------------------------------------------------------------------------
module cat_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cat_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output cat_pkg::t_item  o_item
);
    import cat_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_item            r_slot [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

endmodule

// ===== hdl/cat_back.sv =====
// ----------------------------------------------------------------------------
// cat_back
// Token state machine: comment tracking, one-character hold-back, length
// bound, end of stream; drives the registered result channel.
// ----------------------------------------------------------------------------
module cat_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    input  cat_pkg::t_item  i_item,
    output logic            o_pop,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic [7:0]      o_token_byte,
    output logic            o_token_last,
    output logic            o_token_too_long
);
    import cat_pkg::*;

    logic             r_in_comment;
    logic             r_held_valid;
    logic [7:0]       r_held_byte;
    logic [LEN_W-1:0] r_token_len;
    logic             r_overflowed;
    logic             r_done;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_too_long;

    logic             n_in_comment;
    logic             n_held_valid;
    logic [7:0]       n_held_byte;
    logic [LEN_W-1:0] n_token_len;
    logic             n_overflowed;
    logic             n_done;
    logic             emit;
    logic [7:0]       emit_byte;
    logic             emit_last;
    logic             emit_too_long;
    logic             out_free;
    logic             finish;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = i_item_valid && out_free;

    always_comb begin
        n_in_comment  = r_in_comment;
        n_held_valid  = r_held_valid;
        n_held_byte   = r_held_byte;
        n_token_len   = r_token_len;
        n_overflowed  = r_overflowed;
        n_done        = r_done;
        emit          = 1'b0;
        emit_byte     = r_held_byte;
        emit_last     = 1'b0;
        emit_too_long = 1'b0;
        finish        = 1'b0;

        if (r_done) begin
            finish = 1'b1;
        end else if (i_item.is_nul) begin
            n_done       = 1'b1;
            n_in_comment = 1'b0;
            finish       = 1'b1;
        end else if (r_in_comment) begin
            if (i_item.is_nl)
                n_in_comment = 1'b0;
            if (i_item.eod)
                n_done = 1'b1;
        end else if (i_item.is_nl || i_item.is_sep) begin
            finish = 1'b1;
            if (i_item.eod)
                n_done = 1'b1;
        end else if (r_token_len == '0 && !r_held_valid && i_item.is_hash) begin
            // hash where a token would start opens a comment
            n_in_comment = 1'b1;
            if (i_item.eod)
                n_done = 1'b1;
        end else if (r_token_len >= LEN_W'(MAX_TOKEN_LEN)) begin
            n_overflowed = 1'b1;
            if (i_item.eod) begin
                n_done = 1'b1;
                finish = 1'b1;
            end
        end else begin
            emit         = r_held_valid;
            n_held_byte  = i_item.text;
            n_held_valid = 1'b1;
            n_token_len  = r_token_len + LEN_W'(1);
            if (i_item.eod)
                n_done = 1'b1;
        end

        if (finish) begin
            emit          = r_held_valid;
            emit_last     = 1'b1;
            // overflow flag only matters once a held character goes out
            emit_too_long = r_overflowed || (n_overflowed && !r_overflowed);
            n_held_valid  = 1'b0;
            n_held_byte   = '0;
            n_token_len   = '0;
            n_overflowed  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_comment <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_byte  <= '0;
            r_token_len  <= '0;
            r_overflowed <= 1'b0;
            r_done       <= 1'b0;
        end else if (o_pop) begin
            r_in_comment <= n_in_comment;
            r_held_valid <= n_held_valid;
            r_held_byte  <= n_held_byte;
            r_token_len  <= n_token_len;
            r_overflowed <= n_overflowed;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_pop && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_byte     <= emit_byte;
            r_out_last     <= emit_last;
            r_out_too_long <= emit_too_long;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_token_byte     = r_out_byte;
    assign o_token_last     = r_out_last;
    assign o_token_too_long = r_out_too_long;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> !r_out_too_long)
        else $error("too-long flag on a character that does not end its token");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_token_len <= LEN_W'(MAX_TOKEN_LEN))
        else $error("token length beyond bound");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> r_token_len != '0)
        else $error("held character with empty token");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_comment |-> !r_held_valid)
        else $error("held character while inside a comment");

endmodule

// ===== hdl/comment_aware_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// comment_aware_tokenizer_unit
// Splits a byte stream into tokens, skipping '#' comments, with optional
// lower-casing and a bound on token length.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : one text byte plus end-of-data flag per transfer
//                    (i_in_valid / o_in_stall)
//   output channel : one token character per transfer with last and too-long
//                    flags (o_out_valid / i_out_stall)
//   config port    : i_cfg_we writes i_cfg_index (0 separator bytes,
//                    1 separator count, 2 lower-case enable); write while idle
// Throughput is one byte per cycle while the output is not stalled: the front
// classifies with parallel compares, a two-entry queue decouples it from the
// back, whose token state update feeds the output register combinationally.
// A token character is loaded into the output register when the byte that
// follows it (the hold-back byte or terminator) is popped from the queue.
// After reset configuration is zero and a new stream starts; once the stream
// ends (NUL or end-of-data) the next transfer only drains a held character,
// and only reset starts another stream.
// A stall on the output holds the result register; the queue then fills and
// o_in_stall rises once it holds two bytes, at most two transfers later.
// ----------------------------------------------------------------------------
module comment_aware_tokenizer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cat_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cat_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_text_byte,
    input  logic                           i_end_of_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_token_byte,
    output logic                           o_token_last,
    output logic                           o_token_too_long
);
    import cat_pkg::*;

    t_item push_item;
    t_item pop_item;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;

    cat_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_text_byte   (i_text_byte),
        .i_end_of_data (i_end_of_data),
        .i_q_full      (q_full),
        .o_in_stall    (o_in_stall),
        .o_push        (push),
        .o_item        (push_item)
    );

    cat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (pop_item)
    );

    cat_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (!q_empty),
        .i_item           (pop_item),
        .o_pop            (pop),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_token_byte     (o_token_byte),
        .o_token_last     (o_token_last),
        .o_token_too_long (o_token_too_long)
    );

endmodule
